>>> design/adrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared constants, register indexes, step codes and the command and status
// structures of the disturbance rejection controller.
// ----------------------------------------------------------------------------
package adrc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int STATE_WIDTH_DEF = 48;

    localparam int SAMPLE_W     = 32;
    localparam int GAIN_W       = 48;
    localparam int COEF_W       = 32;
    localparam int DT_W         = 32;
    localparam int DT_FRAC      = 32;
    localparam int CMD_INT_BITS = 11;
    localparam int CMD_LO_US    = 1000;
    localparam int CMD_HI_US    = 2000;

    localparam int MAG_W  = 64;
    localparam int HALF_W = 32;
    localparam int OPW    = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L1          = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L2          = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L3          = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN_RECIP = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME        = 4'd7;

    typedef enum logic [3:0] {
        STEP_D1,
        STEP_D2_GAIN,
        STEP_D2_INPUT,
        STEP_D3,
        STEP_OUT,
        STEP_RATE,
        STEP_DIST,
        STEP_PROP,
        STEP_DERIV,
        STEP_CMD
    } step_t;

    typedef struct packed {
        logic  load_in;
        logic  mul_start;
        logic  write_back;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
    } dp_stat_t;

endpackage

>>> design/adrc_leso_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_leso_controller
// Linear disturbance rejection controller with a third-order extended state
// observer and a clamped pulse-width command output.
// ----------------------------------------------------------------------------
// Each sample request runs ten multiplications through one shared unit that
// forms a product from four 32x32 partial products; each multiplication goes
// through operand load, the partial products, the floor shift and saturation,
// and the write-back. A new request is taken as soon as the previous one has
// reached the output register; the last write-back waits while the output
// register is still full.
// Configuration writes are always accepted and belong between samples.
module adrc_leso_controller
    import adrc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int STATE_WIDTH = STATE_WIDTH_DEF,
    localparam int CMD_W       = FRAC_BITS + CMD_INT_BITS,
    localparam int OUT_TDATA_W = ((CMD_W + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: target_value[31:0], measured_value[63:32].
    input  logic [2*SAMPLE_W-1:0]      s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // Fields from bit 0: drive_command, then zero fill.
    output logic [OUT_TDATA_W-1:0]     m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [CMD_W-1:0] drive_command;

    assign cfg_ready = 1'b1;

    adrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    adrc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .target_value   (s_tdata[SAMPLE_W-1:0]),
        .measured_value (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .cmd            (cmd),
        .stat           (stat),
        .drive_command  (drive_command)
    );

    assign m_tdata = OUT_TDATA_W'(drive_command);

endmodule

>>> design/adrc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_mul
// Shared multi-cycle multiplier: sign and magnitude operands, four 32x32
// partial products, then a floor shift and saturation to the state width.
// ----------------------------------------------------------------------------
module adrc_mul
    import adrc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int STATE_WIDTH = STATE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [MAG_W-1:0]              mag_a,
    input  logic [MAG_W-1:0]              mag_b,
    input  logic                          neg,
    input  logic                          shift_dt,
    output logic                          done,
    output logic signed [STATE_WIDTH-1:0] result
);

    localparam int SW = STATE_WIDTH;
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic [PROD_W-1:0] MIN_MAG = PROD_W'(1) << (SW - 1);

    logic [MAG_W-1:0]  a_reg;
    logic [MAG_W-1:0]  b_reg;
    logic              neg_reg;
    logic              shdt_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [SW-1:0]     res_reg;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [MAG_W-1:0]  pp;
    logic [PROD_W-1:0] pp_ext;
    logic [PROD_W-1:0] pp_sh;
    logic [PROD_W-1:0] acc_next;
    logic [PROD_W-1:0] quot;
    logic              rem_nz;
    logic              high_nz;
    logic              at_min;
    logic [SW-1:0]     q_low;
    logic [SW-1:0]     res_next;

    always_comb
    begin
        a_half = cnt_reg[1] ? a_reg[MAG_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = cnt_reg[0] ? b_reg[MAG_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp     = a_half * b_half;
        pp_ext = {{(PROD_W - MAG_W){1'b0}}, pp};
        if (cnt_reg == 2'b00)
        begin
            pp_sh = pp_ext;
        end
        else if (cnt_reg == 2'b11)
        begin
            pp_sh = pp_ext << (2 * HALF_W);
        end
        else
        begin
            pp_sh = pp_ext << HALF_W;
        end
        acc_next = acc_reg + pp_sh;
    end

    always_comb
    begin
        if (shdt_reg)
        begin
            quot   = acc_reg >> DT_FRAC;
            rem_nz = |acc_reg[DT_FRAC-1:0];
        end
        else
        begin
            quot   = acc_reg >> FRAC_BITS;
            rem_nz = |acc_reg[FRAC_BITS-1:0];
        end
        high_nz = |quot[PROD_W-1:SW-1];
        at_min  = (quot == MIN_MAG);
        q_low   = quot[SW-1:0];
        if (!neg_reg)
        begin
            res_next = high_nz ? S_MAX : q_low;
        end
        else if (!high_nz || (at_min && !rem_nz))
        begin
            res_next = SW'(0) - (q_low + SW'(rem_nz));
        end
        else
        begin
            res_next = S_MIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'b00;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 2'b00;
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 2'b01;
            if (cnt_reg == 2'b11)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= mag_a;
            b_reg    <= mag_b;
            neg_reg  <= neg;
            shdt_reg <= shift_dt;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = $signed(res_reg);

endmodule

>>> design/adrc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_dp
// Datapath: configuration registers, observer states, intermediate terms,
// operand selection for the shared multiplier and saturating write-back.
// ----------------------------------------------------------------------------
module adrc_dp
    import adrc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int STATE_WIDTH = STATE_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    input  logic [SAMPLE_W-1:0]                  target_value,
    input  logic [SAMPLE_W-1:0]                  measured_value,
    input  dp_cmd_t                              cmd,
    output dp_stat_t                             stat,
    output logic [FRAC_BITS+CMD_INT_BITS-1:0]    drive_command
);

    localparam int SW    = STATE_WIDTH;
    localparam int CMD_W = FRAC_BITS + CMD_INT_BITS;
    localparam int CLW   = MAG_W + 8;
    localparam logic signed [SW-1:0]  S_MAX  = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]  S_MIN  = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [CLW-1:0] LIM_LO = CLW'(CMD_LO_US) << FRAC_BITS;
    localparam logic signed [CLW-1:0] LIM_HI = CLW'(CMD_HI_US) << FRAC_BITS;
    localparam logic [COEF_W-1:0]     ONE_FX = COEF_W'(1) << FRAC_BITS;

    logic [GAIN_W-1:0]        gain_l1_reg;
    logic [GAIN_W-1:0]        gain_l2_reg;
    logic [GAIN_W-1:0]        gain_l3_reg;
    logic [COEF_W-1:0]        prop_gain_reg;
    logic [COEF_W-1:0]        deriv_gain_reg;
    logic [COEF_W-1:0]        input_gain_reg;
    logic [COEF_W-1:0]        input_gain_recip_reg;
    logic [DT_W-1:0]          step_time_reg;

    logic signed [SW-1:0]     xo_reg;
    logic signed [SW-1:0]     xr_reg;
    logic signed [SW-1:0]     xd_reg;
    logic [CMD_W-1:0]         last_cmd_reg;

    logic [SAMPLE_W-1:0]      ref_reg;
    logic signed [SW-1:0]     e_reg;
    logic signed [SW-1:0]     d1_reg;
    logic signed [SW-1:0]     d2_reg;
    logic signed [SW-1:0]     d3_reg;
    logic signed [SW-1:0]     v_reg;
    logic [CMD_W-1:0]         drive_reg;

    logic [OPW-1:0]           op_a;
    logic [OPW-1:0]           op_b;
    logic [OPW-1:0]           op_a_abs;
    logic [OPW-1:0]           op_b_abs;
    logic                     shift_dt;
    logic                     mul_done;
    logic signed [SW-1:0]     prod;
    logic signed [SW-1:0]     e_next;
    logic signed [SW-1:0]     track_err;
    logic signed [SW-1:0]     cmd_raw;
    logic signed [CLW-1:0]    cmd_ext;
    logic signed [CLW-1:0]    cmd_clamped;
    logic [CMD_W-1:0]         cmd_next;

    function automatic logic signed [SW-1:0] sat_wide(input logic [SW:0] x);
        logic signed [SW-1:0] r;
        if (x[SW] != x[SW-1])
        begin
            r = x[SW] ? S_MIN : S_MAX;
        end
        else
        begin
            r = $signed(x[SW-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        return sat_wide({a[SW-1], a} + {b[SW-1], b});
    endfunction

    function automatic logic signed [SW-1:0] sat_sub(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        return sat_wide({a[SW-1], a} - {b[SW-1], b});
    endfunction

    function automatic logic signed [SW-1:0] sample_minus(input logic [SAMPLE_W-1:0] s,
                                                          input logic signed [SW-1:0] x);
        return sat_wide({{(SW + 1 - SAMPLE_W){s[SAMPLE_W-1]}}, s} - {x[SW-1], x});
    endfunction

    function automatic logic [OPW-1:0] ext_state(input logic signed [SW-1:0] x);
        return {{(OPW - SW){x[SW-1]}}, x};
    endfunction

    function automatic logic [OPW-1:0] ext_gain(input logic [GAIN_W-1:0] g);
        return {{(OPW - GAIN_W){1'b0}}, g};
    endfunction

    function automatic logic [OPW-1:0] ext_coef(input logic [COEF_W-1:0] c);
        return {{(OPW - COEF_W){c[COEF_W-1]}}, c};
    endfunction

    assign e_next    = sample_minus(measured_value, xo_reg);
    assign track_err = sample_minus(ref_reg, xo_reg);

    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        shift_dt = 1'b0;
        case (cmd.step)
            STEP_D1:
            begin
                op_a = ext_gain(gain_l1_reg);
                op_b = ext_state(e_reg);
            end
            STEP_D2_GAIN:
            begin
                op_a = ext_gain(gain_l2_reg);
                op_b = ext_state(e_reg);
            end
            STEP_D2_INPUT:
            begin
                op_a = ext_coef(input_gain_reg);
                op_b = {{(OPW - CMD_W){1'b0}}, last_cmd_reg};
            end
            STEP_D3:
            begin
                op_a = ext_gain(gain_l3_reg);
                op_b = ext_state(e_reg);
            end
            STEP_OUT:
            begin
                op_a     = ext_state(d1_reg);
                op_b     = {{(OPW - DT_W){1'b0}}, step_time_reg};
                shift_dt = 1'b1;
            end
            STEP_RATE:
            begin
                op_a     = ext_state(d2_reg);
                op_b     = {{(OPW - DT_W){1'b0}}, step_time_reg};
                shift_dt = 1'b1;
            end
            STEP_DIST:
            begin
                op_a     = ext_state(d3_reg);
                op_b     = {{(OPW - DT_W){1'b0}}, step_time_reg};
                shift_dt = 1'b1;
            end
            STEP_PROP:
            begin
                op_a = ext_coef(prop_gain_reg);
                op_b = ext_state(track_err);
            end
            STEP_DERIV:
            begin
                op_a = ext_coef(deriv_gain_reg);
                op_b = ext_state(xr_reg);
            end
            STEP_CMD:
            begin
                op_a = ext_coef(input_gain_recip_reg);
                op_b = ext_state(sat_sub(v_reg, xd_reg));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        op_a_abs = op_a[OPW-1] ? (~op_a + OPW'(1)) : op_a;
        op_b_abs = op_b[OPW-1] ? (~op_b + OPW'(1)) : op_b;
    end

    adrc_mul #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mul_start),
        .mag_a    (op_a_abs[MAG_W-1:0]),
        .mag_b    (op_b_abs[MAG_W-1:0]),
        .neg      (op_a[OPW-1] ^ op_b[OPW-1]),
        .shift_dt (shift_dt),
        .done     (mul_done),
        .result   (prod)
    );

    assign stat.mul_done = mul_done;

    always_comb
    begin
        cmd_raw     = prod;
        cmd_ext     = {{(CLW - SW){cmd_raw[SW-1]}}, cmd_raw};
        if (cmd_ext > LIM_HI)
        begin
            cmd_clamped = LIM_HI;
        end
        else if (cmd_ext < LIM_LO)
        begin
            cmd_clamped = LIM_LO;
        end
        else
        begin
            cmd_clamped = cmd_ext;
        end
        cmd_next = cmd_clamped[CMD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_l1_reg          <= '0;
            gain_l2_reg          <= '0;
            gain_l3_reg          <= '0;
            prop_gain_reg        <= '0;
            deriv_gain_reg       <= '0;
            input_gain_reg       <= ONE_FX;
            input_gain_recip_reg <= ONE_FX;
            step_time_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_L1:          gain_l1_reg          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_L2:          gain_l2_reg          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_L3:          gain_l3_reg          <= cfg_data[GAIN_W-1:0];
                REG_PROP_GAIN:        prop_gain_reg        <= cfg_data[COEF_W-1:0];
                REG_DERIV_GAIN:       deriv_gain_reg       <= cfg_data[COEF_W-1:0];
                REG_INPUT_GAIN:       input_gain_reg       <= cfg_data[COEF_W-1:0];
                REG_INPUT_GAIN_RECIP: input_gain_recip_reg <= cfg_data[COEF_W-1:0];
                REG_STEP_TIME:        step_time_reg        <= cfg_data[DT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xo_reg       <= '0;
            xr_reg       <= '0;
            xd_reg       <= '0;
            last_cmd_reg <= '0;
        end
        else if (cmd.write_back)
        begin
            case (cmd.step)
                STEP_OUT:  xo_reg <= sat_add(xo_reg, prod);
                STEP_RATE: xr_reg <= sat_add(xr_reg, prod);
                STEP_DIST: xd_reg <= sat_add(xd_reg, prod);
                STEP_CMD:  last_cmd_reg <= cmd_next;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ref_reg <= target_value;
            e_reg   <= e_next;
        end
        if (cmd.write_back)
        begin
            case (cmd.step)
                STEP_D1:       d1_reg    <= sat_add(prod, xr_reg);
                STEP_D2_GAIN:  d2_reg    <= sat_add(prod, xd_reg);
                STEP_D2_INPUT: d2_reg    <= sat_add(d2_reg, prod);
                STEP_D3:       d3_reg    <= prod;
                STEP_PROP:     v_reg     <= prod;
                STEP_DERIV:    v_reg     <= sat_sub(v_reg, prod);
                STEP_CMD:      drive_reg <= cmd_next;
                default:
                begin
                end
            endcase
        end
    end

    assign drive_command = drive_reg;

endmodule

>>> design/adrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_ctrl
// Controller: takes a sample request, walks the ten multiply steps through
// the datapath and hands the command to the output register.
// ----------------------------------------------------------------------------
module adrc_ctrl
    import adrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_START = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    step_t  step_reg;
    step_t  step_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   last_step;
    logic   out_free;
    logic   wb;

    always_comb
    begin
        in_fire    = s_tvalid && (state_reg == ST_IDLE);
        last_step  = (step_reg == STEP_CMD);
        out_free   = !out_valid_reg || m_tready;
        wb         = (state_reg == ST_WAIT) && stat.mul_done && (!last_step || out_free);
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_START;
                    step_next  = STEP_D1;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (wb)
                begin
                    if (last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_START;
                        step_next  = step_t'(step_reg + 4'd1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (wb && last_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready       = (state_reg == ST_IDLE);
    assign m_tvalid       = out_valid_reg;
    assign cmd.load_in    = in_fire;
    assign cmd.mul_start  = (state_reg == ST_START);
    assign cmd.write_back = wb;
    assign cmd.step       = step_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_START) && (step_reg == STEP_D1))
        else $error("accepted request did not start the first step");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == ST_WAIT) && (step_reg == STEP_CMD)
                                       && stat.mul_done))
        else $error("result shown without a finished command step");

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |=> !stat.mul_done)
        else $error("multiplier done flag survived a new start");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WAIT) && last_step && stat.mul_done && out_valid_reg && !m_tready)
        |=> (state_reg == ST_WAIT) && (step_reg == STEP_CMD))
        else $error("command step finished while the output register was full");

endmodule
